>>> design/ssh_pkg.sv
// Package for the shot speed histogram statistics block.
// Holds bin constants, label tables, controller command and status types.
// No dependencies; every other module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ssh_pkg;

	localparam int NUM_BINS    = 22;
	localparam int BIN_IDX_W   = 5;
	localparam int SPEED_W     = 16;
	localparam int SCORE_W     = 8;
	localparam int RES_W       = 15;
	localparam int OUT_COUNT_W = 16;
	localparam int DIV_QW      = 16;
	localparam int DIV_STEPS   = 16;
	localparam int DIV_CNT_W   = 5;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 64;

	localparam logic [SPEED_W-1:0] BIN_FIRST_LO = 16'd26000;
	localparam logic [SPEED_W-1:0] BIN_FIRST_HI = 16'd27000;
	localparam logic [SPEED_W-1:0] BIN_LAST_HI  = 16'd29100;
	localparam logic [10:0]        BIN_RECIP    = 11'd1311;
	localparam int                 BIN_RECIP_SHIFT = 17;

	localparam logic [8:0] LABEL_FIRST = 9'd260;
	localparam logic [8:0] LABEL_BASE  = 9'd269;

	localparam logic [SCORE_W-1:0] SCORE_RESET = 8'd64;
	localparam logic [SCORE_W-1:0] SCORE_DROP  = 8'd3;
	localparam logic [SCORE_W-1:0] SCORE_RISE  = 8'd1;

	localparam logic [SPEED_W-1:0] HIGH_THR_RESET = 16'd28500;
	localparam logic [SPEED_W-1:0] LOW_THR_RESET  = 16'd27500;

	localparam logic [RES_W-1:0]       MEAN_MAX      = 15'd29000;
	localparam logic [RES_W-1:0]       VAR_MAX       = 15'd22500;
	localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = 16'hFFFF;

	localparam logic [1:0] SHOOTER_ONE = 2'd1;
	localparam logic [1:0] SHOOTER_TWO = 2'd2;

	typedef enum logic {
		REG_HIGH_THR = 1'b0,
		REG_LOW_THR  = 1'b1
	} ssh_reg_idx_t;

	typedef enum logic [1:0] {
		MUL_N_S2  = 2'd0,
		MUL_S1_S1 = 2'd1,
		MUL_N_N   = 2'd2
	} ssh_mul_sel_t;

	typedef enum logic {
		DIV_MEAN = 1'b0,
		DIV_VAR  = 1'b1
	} ssh_div_sel_t;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_UPDATE  = 8'b0000_0010,
		ST_SUM     = 8'b0000_0100,
		ST_MUL_LD  = 8'b0000_1000,
		ST_MUL_RUN = 8'b0001_0000,
		ST_DIV_LD  = 8'b0010_0000,
		ST_DIV_RUN = 8'b0100_0000,
		ST_DONE    = 8'b1000_0000
	} ssh_state_t;

	typedef struct packed {
		logic         load;
		logic         update;
		logic         sum_step;
		logic         mul_load;
		logic         mul_step;
		logic         mul_store;
		ssh_mul_sel_t mul_sel;
		logic         div_load;
		logic         div_step;
		logic         div_store;
		ssh_div_sel_t div_sel;
		logic         out_load;
	} ssh_cmd_t;

	typedef struct packed {
		logic sum_last;
		logic mul_done;
		logic div_done;
		logic out_free;
	} ssh_sts_t;

	typedef struct packed {
		logic                 hit;
		logic [BIN_IDX_W-1:0] idx;
	} ssh_bin_t;

	// Bins above the first are 0.1 m/s wide; the division by 100 is a
	// reciprocal multiply that is exact over the 2100 values in range.
	function automatic ssh_bin_t bin_of(input logic [SPEED_W-1:0] spd);
		ssh_bin_t    r;
		logic [11:0] x;
		logic [23:0] p;
		r.hit = 1'b0;
		r.idx = '0;
		x = 12'(spd - BIN_FIRST_HI - 16'd1);
		p = 24'(x) * 24'(BIN_RECIP);
		if (spd >= BIN_FIRST_LO && spd <= BIN_FIRST_HI) begin
			r.hit = 1'b1;
		end else if (spd > BIN_FIRST_HI && spd <= BIN_LAST_HI) begin
			r.hit = 1'b1;
			r.idx = BIN_IDX_W'(p >> BIN_RECIP_SHIFT) + BIN_IDX_W'(1);
		end
		return r;
	endfunction

	function automatic logic [8:0] bin_label(input logic [BIN_IDX_W-1:0] idx);
		return (idx == '0) ? LABEL_FIRST : LABEL_BASE + 9'(idx);
	endfunction

	function automatic logic [16:0] bin_label_sq(input logic [BIN_IDX_W-1:0] idx);
		logic [8:0]  l;
		logic [17:0] p;
		l = bin_label(idx);
		p = 18'(l) * 18'(l);
		return p[16:0];
	endfunction

endpackage

`default_nettype wire

>>> design/shot_speed_histogram_stats_core.sv
// Top level of the shot speed histogram statistics block.
// Instantiates ssh_ctrl, ssh_hist and ssh_arith; uses ssh_pkg.
//
// Usage:
// - Input stream (s_axis_*): one request per shot, carrying shooter number
//   and speed in 0.001 m/s. Output stream (m_axis_*): one result per shot
//   with count, mean, variance and both shooter scores.
// - Configuration: cfg_we with cfg_index 0 writes the high speed threshold,
//   index 1 the low speed threshold, from cfg_wdata; the user writes only
//   while the block is idle, which the block itself does not enforce.
// - Processing: update, bin sum over the 22 bins, shift-add multiplier (one
//   operand bit per cycle, three products), then the 16-step restoring
//   divider (mean, then variance).
// - Throughput: one shot at a time; s_axis_tready is high only while the
//   sequencer is idle.
// - A finished result sits in the output register; the next shot is
//   accepted and processed while it waits. If the receiver still stalls
//   when that next result is ready, the sequencer holds it until the
//   output register frees.
// - Reset clears all bins, the total and sets both scores to 64 and the
//   thresholds to 28.5 and 27.5 m/s. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module shot_speed_histogram_stats_core import ssh_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [1:0] shooter_id, [17:2] speed, [23:18] zero
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [15:0] shot_count, [30:16] mean_speed, [45:31] speed_variance,
	// [53:46] score_one, [61:54] score_two, [63:62] zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [SPEED_W-1:0]    cfg_wdata
);

	localparam int CXW = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

	ssh_cmd_t cmd;
	ssh_sts_t sts;

	logic [SPEED_W-1:0]     high_thr_q, low_thr_q;
	logic                   m_valid_q;
	logic [OUT_DATA_W-1:0]  m_data_q;

	logic [COUNT_WIDTH-1:0]  total;
	logic [COUNT_WIDTH+12:0] s1;
	logic [COUNT_WIDTH+20:0] s2;
	logic [SCORE_W-1:0]      score_one, score_two;
	logic [RES_W-1:0]        mean, variance;
	logic                    sum_last, mul_done, div_done;
	logic [CXW-1:0]          total_x;
	logic [OUT_COUNT_W-1:0]  shot_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_THR_RESET;
			low_thr_q  <= LOW_THR_RESET;
		end else if (cfg_we) begin
			unique case (ssh_reg_idx_t'(cfg_index))
				REG_HIGH_THR: high_thr_q <= cfg_wdata;
				REG_LOW_THR:  low_thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign sts.sum_last = sum_last;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_valid_q || m_axis_tready;

	ssh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssh_hist #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.shooter_id (s_axis_tdata[1:0]),
		.speed      (s_axis_tdata[17:2]),
		.high_thr   (high_thr_q),
		.low_thr    (low_thr_q),
		.total      (total),
		.s1         (s1),
		.s2         (s2),
		.score_one  (score_one),
		.score_two  (score_two),
		.sum_last   (sum_last)
	);

	ssh_arith #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.n        (total),
		.s1       (s1),
		.s2       (s2),
		.mul_done (mul_done),
		.div_done (div_done),
		.mean     (mean),
		.variance (variance)
	);

	assign total_x    = CXW'(total);
	assign shot_count = (total_x > CXW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
	                                                     : total_x[OUT_COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= {2'b00, score_two, score_one, variance, mean, shot_count};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

>>> design/ssh_ctrl.sv
// Controller state machine of the shot speed histogram statistics block.
// Sequences update, bin sum, three multiplies and two divides; uses ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssh_ctrl import ssh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire ssh_sts_t sts,
	output ssh_cmd_t      cmd
);

	ssh_state_t   state_q, state_d;
	ssh_mul_sel_t mul_sel_q, mul_sel_d;
	ssh_div_sel_t div_sel_q, div_sel_d;

	always_comb begin
		state_d     = state_q;
		mul_sel_d   = mul_sel_q;
		div_sel_d   = div_sel_q;
		cmd         = '0;
		cmd.mul_sel = mul_sel_q;
		cmd.div_sel = div_sel_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_last) begin
					mul_sel_d = MUL_N_S2;
					state_d   = ST_MUL_LD;
				end
			end
			ST_MUL_LD: begin
				cmd.mul_load = 1'b1;
				state_d      = ST_MUL_RUN;
			end
			ST_MUL_RUN: begin
				if (sts.mul_done) begin
					cmd.mul_store = 1'b1;
					unique case (mul_sel_q)
						MUL_N_S2: begin
							mul_sel_d = MUL_S1_S1;
							state_d   = ST_MUL_LD;
						end
						MUL_S1_S1: begin
							mul_sel_d = MUL_N_N;
							state_d   = ST_MUL_LD;
						end
						default: begin
							div_sel_d = DIV_MEAN;
							state_d   = ST_DIV_LD;
						end
					endcase
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			ST_DIV_LD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (div_sel_q == DIV_VAR) begin
						state_d = ST_DONE;
					end else begin
						div_sel_d = DIV_VAR;
						state_d   = ST_DIV_LD;
					end
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mul_sel_q <= MUL_N_S2;
			div_sel_q <= DIV_MEAN;
		end else begin
			state_q   <= state_d;
			mul_sel_q <= mul_sel_d;
			div_sel_q <= div_sel_d;
		end
	end

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> state_q == ST_DONE)
		else $error("finished result dropped while output was busy");

	a_load_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_UPDATE && !in_ready))
		else $error("accepted request did not start an update");

	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_store && cmd.mul_sel == MUL_N_N) |=>
		(state_q == ST_DIV_LD && div_sel_q == DIV_MEAN))
		else $error("division did not start with the mean after the last multiply");

endmodule

`default_nettype wire

>>> design/ssh_hist.sv
// Histogram datapath: bin counters, shot total, shooter scores and the
// iterative sums of count*label and count*label^2; uses ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssh_hist import ssh_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ssh_cmd_t               cmd,
	input  wire logic [1:0]             shooter_id,
	input  wire logic [SPEED_W-1:0]     speed,
	input  wire logic [SPEED_W-1:0]     high_thr,
	input  wire logic [SPEED_W-1:0]     low_thr,
	output logic [COUNT_WIDTH-1:0]      total,
	output logic [COUNT_WIDTH+12:0]     s1,
	output logic [COUNT_WIDTH+20:0]     s2,
	output logic [SCORE_W-1:0]          score_one,
	output logic [SCORE_W-1:0]          score_two,
	output logic                        sum_last
);

	localparam int S1W = COUNT_WIDTH + 13;
	localparam int S2W = COUNT_WIDTH + 21;

	logic [COUNT_WIDTH-1:0] bins_q [NUM_BINS];
	logic [COUNT_WIDTH-1:0] total_q;
	logic [SCORE_W-1:0]     score_one_q, score_two_q;
	logic [BIN_IDX_W-1:0]   sum_idx_q;
	logic [1:0]             id_q;
	logic [SPEED_W-1:0]     speed_q;
	logic [S1W-1:0]         s1_q;
	logic [S2W-1:0]         s2_q;

	ssh_bin_t                bin;
	logic [BIN_IDX_W-1:0]    rd_idx;
	logic [COUNT_WIDTH-1:0]  rd_cnt;
	logic [COUNT_WIDTH+8:0]  prod1;
	logic [COUNT_WIDTH+16:0] prod2;
	logic                    is_high, is_low;

	assign bin     = bin_of(speed_q);
	assign rd_idx  = cmd.update ? bin.idx : sum_idx_q;
	assign rd_cnt  = bins_q[rd_idx];
	assign prod1   = (COUNT_WIDTH + 9)'(rd_cnt) * (COUNT_WIDTH + 9)'(bin_label(sum_idx_q));
	assign prod2   = (COUNT_WIDTH + 17)'(rd_cnt) * (COUNT_WIDTH + 17)'(bin_label_sq(sum_idx_q));
	assign is_high = (speed_q >= high_thr);
	assign is_low  = (speed_q <= low_thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
			total_q     <= '0;
			score_one_q <= SCORE_RESET;
			score_two_q <= SCORE_RESET;
			sum_idx_q   <= '0;
		end else begin
			if (cmd.update) begin
				if (bin.hit && rd_cnt != '1) begin
					bins_q[bin.idx] <= rd_cnt + COUNT_WIDTH'(1);
				end
				if (total_q != '1) begin
					total_q <= total_q + COUNT_WIDTH'(1);
				end
				if (id_q == SHOOTER_ONE) begin
					if (is_high) begin
						score_one_q <= score_one_q - SCORE_DROP;
					end else if (is_low) begin
						score_one_q <= score_one_q + SCORE_RISE;
					end
				end
				if (id_q == SHOOTER_TWO) begin
					if (is_high) begin
						score_two_q <= score_two_q - SCORE_DROP;
					end else if (is_low) begin
						score_two_q <= score_two_q + SCORE_RISE;
					end
				end
				sum_idx_q <= '0;
			end else if (cmd.sum_step) begin
				sum_idx_q <= sum_last ? '0 : sum_idx_q + BIN_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q    <= shooter_id;
			speed_q <= speed;
		end
		if (cmd.update) begin
			s1_q <= '0;
			s2_q <= '0;
		end else if (cmd.sum_step) begin
			s1_q <= s1_q + S1W'(prod1);
			s2_q <= s2_q + S2W'(prod2);
		end
	end

	assign sum_last  = (sum_idx_q == BIN_IDX_W'(NUM_BINS - 1));
	assign total     = total_q;
	assign s1        = s1_q;
	assign s2        = s2_q;
	assign score_one = score_one_q;
	assign score_two = score_two_q;

endmodule

`default_nettype wire

>>> design/ssh_arith.sv
// Arithmetic datapath: shift-add multiplier and restoring divider that turn
// the histogram sums into mean and variance; uses ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssh_arith import ssh_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ssh_cmd_t               cmd,
	input  wire logic [COUNT_WIDTH-1:0] n,
	input  wire logic [COUNT_WIDTH+12:0] s1,
	input  wire logic [COUNT_WIDTH+20:0] s2,
	output logic                        mul_done,
	output logic                        div_done,
	output logic [RES_W-1:0]            mean,
	output logic [RES_W-1:0]            variance
);

	localparam int MBW  = COUNT_WIDTH + 13;
	localparam int PW   = 2 * COUNT_WIDTH + 26;
	localparam int DENW = 2 * COUNT_WIDTH;
	localparam int NUMW = 2 * COUNT_WIDTH + 28;

	logic [PW-1:0]        mul_a_q, acc_q, ns2_q, s1sq_q, diff_q;
	logic [MBW-1:0]       mul_b_q;
	logic [DENW-1:0]      den_q;
	logic                 pos_q;
	logic [NUMW-1:0]      rem_q, dsh_q;
	logic [DIV_QW-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic [RES_W-1:0]     mean_q, var_q;

	logic [NUMW-1:0] num_src, num100, den_src;
	logic            rem_ge;

	always_comb begin
		if (cmd.div_sel == DIV_MEAN) begin
			num_src = NUMW'(s1);
			den_src = NUMW'(n);
		end else begin
			num_src = pos_q ? NUMW'(diff_q) : '0;
			den_src = NUMW'(den_q);
		end
	end

	// Times 100 as 64 + 32 + 4.
	assign num100 = (num_src << 6) + (num_src << 5) + (num_src << 2);
	assign rem_ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_b_q <= '0;
			dcnt_q  <= '0;
		end else begin
			if (cmd.mul_load) begin
				unique case (cmd.mul_sel)
					MUL_N_S2:  mul_b_q <= MBW'(n);
					MUL_S1_S1: mul_b_q <= MBW'(s1);
					MUL_N_N:   mul_b_q <= MBW'(n);
					default:   mul_b_q <= '0;
				endcase
			end else if (cmd.mul_step) begin
				mul_b_q <= mul_b_q >> 1;
			end
			if (cmd.div_load) begin
				dcnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			acc_q <= '0;
			unique case (cmd.mul_sel)
				MUL_N_S2:  mul_a_q <= PW'(s2);
				MUL_S1_S1: mul_a_q <= PW'(s1);
				MUL_N_N:   mul_a_q <= PW'(n);
				default:   mul_a_q <= '0;
			endcase
		end else if (cmd.mul_step) begin
			if (mul_b_q[0]) begin
				acc_q <= acc_q + mul_a_q;
			end
			mul_a_q <= mul_a_q << 1;
		end
		if (cmd.mul_store) begin
			unique case (cmd.mul_sel)
				MUL_N_S2:  ns2_q <= acc_q;
				MUL_S1_S1: s1sq_q <= acc_q;
				default: begin
					den_q  <= DENW'(acc_q);
					pos_q  <= (ns2_q > s1sq_q);
					diff_q <= ns2_q - s1sq_q;
				end
			endcase
		end
		if (cmd.div_load) begin
			rem_q <= num100;
			dsh_q <= den_src << (DIV_QW - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[DIV_QW-2:0], rem_ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.div_store) begin
			if (cmd.div_sel == DIV_MEAN) begin
				mean_q <= (quo_q > DIV_QW'(MEAN_MAX)) ? MEAN_MAX : quo_q[RES_W-1:0];
			end else begin
				var_q <= (quo_q > DIV_QW'(VAR_MAX)) ? VAR_MAX : quo_q[RES_W-1:0];
			end
		end
	end

	assign mul_done = (mul_b_q == '0);
	assign div_done = (dcnt_q == '0);
	assign mean     = mean_q;
	assign variance = var_q;

	a_var_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_store && cmd.div_sel == DIV_VAR) |=> (var_q <= VAR_MAX))
		else $error("variance above its saturation limit");

endmodule

`default_nettype wire
